FILE: rtl/core/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the work-stealing deque core.
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam int DEPTH       = 64;
   localparam int IDX_BITS    = $clog2(DEPTH);
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   localparam int HANDLE_BITS = 32;
   localparam int OP_BITS     = 2;
   localparam int ST_BITS     = 2;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_POP   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_STEAL = 2'd2;
   localparam logic [OP_BITS-1:0] OP_NOP   = 2'd3;

   // result status codes
   localparam logic [ST_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [ST_BITS-1:0] ST_EMPTY   = 2'd1;
   localparam logic [ST_BITS-1:0] ST_RESERVE = 2'd2;
   localparam logic [ST_BITS-1:0] ST_FULL    = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic execute;   // decide, update pointers, access the store
      logic load;      // move the result into the output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;  // output register holds an item that is not taken
   } dp_stat_type;

endpackage

FILE: rtl/core/wsd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_ctrl
// Sequencer for the deque: accept, execute, load result.
// ----------------------------------------------------------------------------
module wsd_ctrl import wsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_LOAD = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_LOAD;
         end
         S_LOAD: begin
            // hold until the output register is free
            if (!stat.out_busy) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted item did not start execution");
   a_exec_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (state_ff == S_LOAD))
      else $error("execution did not move to load");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == S_IDLE) && !cmd.execute && !cmd.load)
      else $error("ready raised while an item is in flight");
`endif

endmodule

FILE: rtl/core/wsd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_datapath
// Handle store, head/tail pointers, entry count and the output register.
// ----------------------------------------------------------------------------
module wsd_datapath import wsd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_stat_type            stat,
   input  logic [OP_BITS-1:0]     req_opcode,
   input  logic [HANDLE_BITS-1:0] req_task,
   input  logic                   csr_we,
   input  logic [CNT_BITS-1:0]    csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ST_BITS-1:0]     rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_task,
   output logic [CNT_BITS-1:0]    rsp_held
);

   logic [HANDLE_BITS-1:0] store_mem [DEPTH];
   logic [HANDLE_BITS-1:0] rd_data_ff;

   logic [OP_BITS-1:0]     op_ff;
   logic [HANDLE_BITS-1:0] task_ff;
   logic [CNT_BITS-1:0]    reserve_ff;
   logic [IDX_BITS-1:0]    head_ff, head_in;
   logic [IDX_BITS-1:0]    tail_ff, tail_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [ST_BITS-1:0]     status_ff, status_in;
   logic                   hit_ff, hit_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ST_BITS-1:0]     rsp_status_ff;
   logic [HANDLE_BITS-1:0] rsp_task_ff;
   logic [CNT_BITS-1:0]    rsp_held_ff;

   logic                   mem_we;
   logic                   mem_re;
   logic [IDX_BITS-1:0]    mem_addr;
   logic [IDX_BITS-1:0]    head_next;
   logic [IDX_BITS-1:0]    tail_next;
   logic [IDX_BITS-1:0]    tail_prev;

   assign head_next = (head_ff == IDX_BITS'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_BITS'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? IDX_BITS'(DEPTH - 1) : tail_ff - 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = status_ff;
      hit_in    = hit_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = tail_ff;
      if (cmd.execute) begin
         status_in = ST_OK;
         hit_in    = 1'b0;
         unique case (op_ff)
            OP_PUSH: begin
               if (count_ff == CNT_BITS'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  mem_addr = tail_ff;
                  tail_in  = tail_next;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  mem_re   = 1'b1;
                  mem_addr = tail_prev;
                  hit_in   = 1'b1;
                  tail_in  = tail_prev;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_STEAL: begin
               priority if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else if (count_ff <= reserve_ff) begin
                  status_in = ST_RESERVE;
               end else begin
                  mem_re   = 1'b1;
                  mem_addr = head_ff;
                  hit_in   = 1'b1;
                  head_in  = head_next;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_NOP: begin
               status_in = ST_OK;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= task_ff;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         task_ff <= req_task;
      end
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         reserve_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (csr_we) begin
            reserve_ff <= csr_wdata;
         end
      end
   end

   // output register: drop valid once taken, reload on command
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_task_ff   <= hit_ff ? rd_data_ff : '0;
         rsp_held_ff   <= count_ff;
      end
   end

   assign stat.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_task      = rsp_task_ff;
   assign rsp_held      = rsp_held_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count above depth");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty deque with head and tail apart");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_task_ff == '0))
      else $error("failed operation returned a handle");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

FILE: rtl/core/work_stealing_deque_core.sv
`timescale 1ns / 1ps
// Flow: an accepted request passes S_EXEC and then S_LOAD; rsp_tvalid rises once S_LOAD loads the free output register.
// Requests: a new request is taken only in S_IDLE, once the previous one has been through
//   the accept/execute/load sequence and the registered read of the handle store.
// Reset: synchronous active-high reset empties the deque, clears the steal
//   reserve to 0 and drops any pending result; store contents are kept.
// ----------------------------------------------------------------------------
// work_stealing_deque_core
// Circular task deque with push/pop at the tail and reserve-gated steal.
// ----------------------------------------------------------------------------
module work_stealing_deque_core import wsd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [39:0]         req_tdata,   // [1:0] opcode, [33:2] task_in, rest zero
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,   // [1:0] status, [33:2] task_out, [40:34] held
   input  logic                csr_we,
   input  logic [CNT_BITS-1:0] csr_wdata
);

   ctrl_cmd_type           cmd;
   dp_stat_type            stat;
   logic [ST_BITS-1:0]     rsp_status;
   logic [HANDLE_BITS-1:0] rsp_task;
   logic [CNT_BITS-1:0]    rsp_held;

   wsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wsd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_opcode (req_tdata[1:0]),
      .req_task   (req_tdata[33:2]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_task   (rsp_task),
      .rsp_held   (rsp_held)
   );

   assign rsp_tdata = {7'd0, rsp_held, rsp_task, rsp_status};

endmodule
